/* hw/rtl/rpe_pkg.sv */
// ----------------------------------------------------------------------------
// rpe_pkg
// Shared types and fixed constants of the RMS / peak envelope follower.
// ----------------------------------------------------------------------------
`default_nettype none

package rpe_pkg;

  // Fraction bits of the detector level and of the envelope.
  localparam int DET_FRAC   = 16;
  // Coefficient format: Q0.16, one is 2^16.
  localparam int COEF_W     = 16;
  localparam int COEF_ONE   = 65536;
  localparam int ROUND_HALF = 32768;
  // Output field width.
  localparam int OUT_W      = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DETECT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF = 2'd2;

  // Detector modes.
  localparam logic MODE_PEAK = 1'b0;
  localparam logic MODE_RMS  = 1'b1;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;     // update the accumulator
    logic clear;  // start from zero instead of the held sum
    logic round;  // add one half LSB of the Q16 result
  } mac_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/rpe_sample_if.sv */
// ----------------------------------------------------------------------------
// rpe_sample_if
// Input sample channel: valid/ready handshake carrying one signed sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpe_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rpe_env_if.sv */
// ----------------------------------------------------------------------------
// rpe_env_if
// Output envelope channel: valid/ready handshake carrying one envelope value.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpe_env_if;
  import rpe_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] envelope_out;

  modport source (output valid, output envelope_out, input ready);
  modport sink   (input valid, input envelope_out, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rpe_cfg_if.sv */
// ----------------------------------------------------------------------------
// rpe_cfg_if
// Configuration write channel: valid/ready handshake with index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpe_cfg_if;
  import rpe_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rpe_ram.sv */
// ----------------------------------------------------------------------------
// rpe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rpe_sub.sv */
// ----------------------------------------------------------------------------
// rpe_sub
// Shared trial subtractor: difference and a >= b flag for divide and root.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_sub #(
  parameter int W = 34
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic      [W-1:0] diff,
  output logic              ge
);

  logic borrow;

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign ge = ~borrow;

endmodule

`default_nettype wire

/* hw/rtl/rpe_mac.sv */
// ----------------------------------------------------------------------------
// rpe_mac
// Shared multiply-accumulate unit: one product per cycle into a register while ctl.en is set.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_mac #(
  parameter int A_W = 32,
  parameter int B_W = 17,
  parameter int ACC_W = A_W + B_W
) (
  input  wire logic               clk,
  input  wire rpe_pkg::mac_ctl_t  ctl,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic      [ACC_W-1:0]   acc
);
  import rpe_pkg::*;

  logic [ACC_W-1:0] prod;
  logic [ACC_W-1:0] base;
  logic [ACC_W-1:0] bias;

  assign prod = ACC_W'(a) * ACC_W'(b);
  assign base = ctl.clear ? '0 : acc;
  assign bias = ctl.round ? ACC_W'(ROUND_HALF) : '0;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= base + prod + bias;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rms_peak_envelope_follower.sv */
// ----------------------------------------------------------------------------
// rms_peak_envelope_follower
// Peak or sliding-window RMS detector followed by an attack/release smoother.
// ----------------------------------------------------------------------------
// Sequence: RMS mode runs LOAD, UPD, DIV, SQRT, MULA, MULB and FIN from request
//   accept to result valid; peak mode runs MULA, MULB and FIN. FIN holds until
//   the output register is free; no new request is taken before IDLE. Divide
//   (bit-serial) and root (two bits per step) share the trial subtractor.
// Reset (rst, synchronous): clears envelope, window sum, count, pointer and
//   registers (detect_mode=1, attack=65000, release=65500); no RAM sweep.
`default_nettype none

module rms_peak_envelope_follower #(
  parameter int WINDOW_DEPTH = 1024,
  parameter int SAMPLE_BITS  = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  rpe_sample_if.sink sample,
  rpe_env_if.source  envelope,
  rpe_cfg_if.sink    cfg
);
  import rpe_pkg::*;

  // --------------------------------------------------------------------------
  // Derived widths
  // --------------------------------------------------------------------------
  localparam int SB     = SAMPLE_BITS;
  localparam int SQ_W   = 2 * SB - 1;                      // mag^2 fits exactly
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);        // holds WINDOW_DEPTH
  localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = SQ_W + CNT_W;                    // window total
  localparam int ROOT_W = SB + DET_FRAC;                   // root / level width
  localparam int LVL_W  = ROOT_W;
  localparam int RAD_W  = 2 * ROOT_W;                      // quotient << 32
  localparam int SUB_W  = (CNT_W + 1 > ROOT_W + 2) ? CNT_W + 1 : ROOT_W + 2;
  localparam int B_W    = (SB > COEF_W + 1) ? SB : COEF_W + 1;
  localparam int ACC_W  = LVL_W + B_W;
  localparam int INT_W  = LVL_W - DET_FRAC;
  localparam int MAX_ST = (SUM_W > ROOT_W) ? SUM_W : ROOT_W;
  localparam int STEP_W = $clog2(MAX_ST);

  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_LOAD = 8'b0000_0010,   // square the sample, read the oldest slot
    ST_UPD  = 8'b0000_0100,   // update window sum, ring and count
    ST_DIV  = 8'b0000_1000,   // sum / count, one quotient bit a cycle
    ST_SQRT = 8'b0001_0000,   // root of quotient * 2^32, one bit a cycle
    ST_MULA = 8'b0010_0000,   // acc = env * coef + half
    ST_MULB = 8'b0100_0000,   // acc += level * (1 - coef)
    ST_FIN  = 8'b1000_0000    // commit envelope, load output register
  } state_t;

  state_t state;

  // Configuration registers
  logic              detect_mode;
  logic [COEF_W-1:0] attack_coef;
  logic [COEF_W-1:0] release_coef;

  // Window state
  logic [PTR_W-1:0]  ring_pointer;
  logic [SUM_W-1:0]  square_sum;
  logic [CNT_W-1:0]  seen_count;
  logic [LVL_W-1:0]  envelope_level;

  // Per-request working registers
  logic [SB-1:0]     mag;
  logic [SUM_W-1:0]  dq;          // dividend shifting out, quotient shifting in
  logic [SUB_W-1:0]  rem;         // partial remainder, shared by divide and root
  logic [RAD_W-1:0]  rad;         // radicand, two bits leave per step
  logic [ROOT_W-1:0] root;
  logic [STEP_W-1:0] step;
  logic [LVL_W-1:0]  level;
  logic [COEF_W-1:0] coef_sel;

  // Output register
  logic              out_valid;
  logic [OUT_W-1:0]  out_data;

  // --------------------------------------------------------------------------
  // Handshakes; hold both input channels off while in reset.
  // --------------------------------------------------------------------------
  logic in_fire;
  logic out_free;

  assign sample.ready          = (state == ST_IDLE) & ~rst;
  assign in_fire               = sample.valid & sample.ready;
  assign envelope.valid        = out_valid;
  assign envelope.envelope_out = out_data;
  assign out_free              = ~out_valid | envelope.ready;
  assign cfg.ready             = ~rst;

  // Magnitude of the incoming sample; the most negative code maps to 2^(SB-1).
  logic [SB-1:0] raw;
  logic [SB-1:0] mag_in;

  assign raw    = sample.sample_in;
  assign mag_in = raw[SB-1] ? SB'(~raw + 1'b1) : raw;

  // --------------------------------------------------------------------------
  // Ring of squares. Slots at or past seen_count were never written and
  // stand for zero, so the warm-up count replaces a clearing pass.
  // --------------------------------------------------------------------------
  logic             ram_we;
  logic             ram_re;
  logic [SQ_W-1:0]  ram_rdata;
  logic [SQ_W-1:0]  sq;
  logic [SQ_W-1:0]  old_sq;
  logic             warm;
  logic [SUM_W-1:0] sum_new;
  logic [ACC_W-1:0] acc;

  assign ram_re  = (state == ST_LOAD);
  assign ram_we  = (state == ST_UPD);
  assign sq      = acc[SQ_W-1:0];
  assign warm    = (seen_count < CNT_W'(WINDOW_DEPTH));
  assign old_sq  = warm ? '0 : ram_rdata;
  assign sum_new = square_sum + SUM_W'(sq) - SUM_W'(old_sq);

  rpe_ram #(
    .WIDTH (SQ_W),
    .DEPTH (WINDOW_DEPTH),
    .ADDR_W(PTR_W)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ring_pointer),
    .wdata(sq),
    .re   (ram_re),
    .raddr(ring_pointer),
    .rdata(ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Shared trial subtractor: restoring divide step or square root step.
  // --------------------------------------------------------------------------
  logic [SUB_W-1:0]  sub_a;
  logic [SUB_W-1:0]  sub_b;
  logic [SUB_W-1:0]  sub_diff;
  logic              sub_ge;
  logic [SUM_W-1:0]  dq_next;
  logic [ROOT_W-1:0] root_next;

  always_comb begin
    if (state == ST_DIV) begin
      // bring down the next dividend bit, try to take the count off
      sub_a = SUB_W'({rem[CNT_W-1:0], dq[SUM_W-1]});
      sub_b = SUB_W'(seen_count);
    end else begin
      // bring down the next radicand pair, try (root << 2) | 1
      sub_a = SUB_W'({rem[ROOT_W-1:0], rad[RAD_W-1 -: 2]});
      sub_b = SUB_W'({root[ROOT_W-2:0], 2'b01});
    end
  end

  rpe_sub #(
    .W(SUB_W)
  ) u_sub (
    .a   (sub_a),
    .b   (sub_b),
    .diff(sub_diff),
    .ge  (sub_ge)
  );

  assign dq_next   = {dq[SUM_W-2:0], sub_ge};
  assign root_next = {root[ROOT_W-2:0], sub_ge};

  // --------------------------------------------------------------------------
  // Shared multiplier: squares the sample, then runs the two smoother terms.
  // --------------------------------------------------------------------------
  mac_ctl_t         mac_ctl;
  logic [LVL_W-1:0] mac_a;
  logic [B_W-1:0]   mac_b;
  logic [COEF_W-1:0] coef_pick;

  assign coef_pick = (envelope_level < level) ? attack_coef : release_coef;

  always_comb begin
    mac_ctl = '0;
    mac_a   = level;
    mac_b   = B_W'((COEF_W + 1)'(COEF_ONE) - (COEF_W + 1)'(coef_sel));
    case (state)
      ST_LOAD: begin
        mac_ctl = '{en: 1'b1, clear: 1'b1, round: 1'b0};
        mac_a   = LVL_W'(mag);
        mac_b   = B_W'(mag);
      end
      ST_MULA: begin
        mac_ctl = '{en: 1'b1, clear: 1'b1, round: 1'b1};
        mac_a   = envelope_level;
        mac_b   = B_W'(coef_pick);
      end
      ST_MULB: begin
        mac_ctl = '{en: 1'b1, clear: 1'b0, round: 1'b0};
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  rpe_mac #(
    .A_W  (LVL_W),
    .B_W  (B_W),
    .ACC_W(ACC_W)
  ) u_mac (
    .clk(clk),
    .ctl(mac_ctl),
    .a  (mac_a),
    .b  (mac_b),
    .acc(acc)
  );

  // New envelope and its saturated integer part.
  logic [LVL_W-1:0]       env_new;
  logic [INT_W+OUT_W-1:0] env_wide;
  logic [OUT_W-1:0]       env_sat;

  assign env_new  = acc[DET_FRAC +: LVL_W];
  assign env_wide = {{OUT_W{1'b0}}, env_new[LVL_W-1:DET_FRAC]};
  assign env_sat  = (env_wide > (INT_W + OUT_W)'({OUT_W{1'b1}})) ?
                    {OUT_W{1'b1}} : env_wide[OUT_W-1:0];

  // --------------------------------------------------------------------------
  // Configuration writes; indices past the register list are dropped.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      detect_mode  <= MODE_RMS;
      attack_coef  <= COEF_W'(65000);
      release_coef <= COEF_W'(65500);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DETECT_MODE:  detect_mode  <= cfg.data[0];
        REG_ATTACK_COEF:  attack_coef  <= cfg.data[COEF_W-1:0];
        REG_RELEASE_COEF: release_coef <= cfg.data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      ring_pointer   <= '0;
      square_sum     <= '0;
      seen_count     <= '0;
      envelope_level <= '0;
      out_valid      <= 1'b0;
    end else begin
      // drop the output once taken; FIN refills it on its own
      if (out_valid && envelope.ready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= (detect_mode == MODE_RMS) ? ST_LOAD : ST_MULA;
          end
        end
        ST_LOAD: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          // swap the oldest square for the new one and advance the ring
          square_sum   <= sum_new;
          ring_pointer <= (ring_pointer == PTR_W'(WINDOW_DEPTH - 1)) ?
                          '0 : ring_pointer + 1'b1;
          if (warm) begin
            seen_count <= seen_count + 1'b1;
          end
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (step == DIV_LAST) begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (step == SQRT_LAST) begin
            state <= ST_MULA;
          end
        end
        ST_MULA: begin
          state <= ST_MULB;
        end
        ST_MULB: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          // hold until the output register can take the result
          if (out_free) begin
            envelope_level <= env_new;
            out_valid      <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers (no reset needed)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          mag   <= mag_in;
          level <= {mag_in, {DET_FRAC{1'b0}}};
        end
      end
      ST_UPD: begin
        dq   <= sum_new;
        rem  <= '0;
        step <= '0;
      end
      ST_DIV: begin
        dq <= dq_next;
        if (step == DIV_LAST) begin
          // quotient times 2^(2*DET_FRAC) is the root's radicand
          rad  <= RAD_W'({dq_next[SQ_W-1:0], {(2 * DET_FRAC){1'b0}}});
          rem  <= '0;
          root <= '0;
          step <= '0;
        end else begin
          rem  <= sub_ge ? sub_diff : sub_a;
          step <= step + 1'b1;
        end
      end
      ST_SQRT: begin
        rem  <= sub_ge ? sub_diff : sub_a;
        root <= root_next;
        rad  <= {rad[RAD_W-3:0], 2'b00};
        step <= step + 1'b1;
        if (step == SQRT_LAST) begin
          level <= root_next;
        end
      end
      ST_MULA: begin
        coef_sel <= coef_pick;
      end
      ST_FIN: begin
        if (out_free) begin
          out_data <= env_sat;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Divider remainder stays below the divisor at every step.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < SUB_W'(seen_count)))
    else $error("divide remainder not below sample count");

  // Root remainder never exceeds twice the partial root.
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT) |-> (rem <= SUB_W'({root, 1'b0})))
    else $error("square root remainder out of range");

  // Smoothed value never overshoots both the old envelope and the level.
  a_env_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> ((env_new <= envelope_level) || (env_new <= level)))
    else $error("smoother overshoot");

  // Ring pointer moves only in the window update cycle.
  a_ptr_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_UPD) |=> $stable(ring_pointer))
    else $error("ring pointer moved outside window update");

  // Warm-up count never passes the window length.
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    seen_count <= CNT_W'(WINDOW_DEPTH))
    else $error("sample count past window length");

endmodule

`default_nettype wire
